>>> design/http_request_line_parser_defines.svh
// ---------------------------------------------------------------------------
// http_request_line_parser_defines
// Assertion macros used by the request line parser checker.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HRLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hrlp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define HRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hrlp assertion failed");

`endif

>>> design/hrlp_pkg.sv
// ---------------------------------------------------------------------------
// hrlp_pkg
// Beat types, field tags, verdict codes and keyword tables of the parser.
// ---------------------------------------------------------------------------
`default_nettype none

package hrlp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       final_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [2:0] field_tag;
		logic       verdict_valid;
		logic [1:0] verdict;
		logic       use_default_port;
	} res_t;

	localparam logic [2:0] TAG_NONE    = 3'd0;
	localparam logic [2:0] TAG_METHOD  = 3'd1;
	localparam logic [2:0] TAG_HOST    = 3'd2;
	localparam logic [2:0] TAG_PORT    = 3'd3;
	localparam logic [2:0] TAG_VERSION = 3'd4;

	localparam logic [1:0] VERDICT_TUNNEL = 2'd0;
	localparam logic [1:0] VERDICT_PLAIN  = 2'd1;
	localparam logic [1:0] VERDICT_BAD    = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam int NUM_METHODS = 7;

	// CONNECT first: it is the only tunnel method
	localparam logic [7:0] METH_TXT [NUM_METHODS][8] = '{
		'{"C", "O", "N", "N", "E", "C", "T", 8'h00},
		'{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
		'{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
		'{"O", "P", "T", "I", "O", "N", "S", 8'h00}
	};
	localparam logic [3:0] METH_LEN [NUM_METHODS] = '{
		4'd7, 4'd3, 4'd4, 4'd6, 4'd4, 4'd5, 4'd7
	};

	localparam logic [7:0] VER_TXT [2][8] = '{
		'{"H", "T", "T", "P", "/", "1", ".", "0"},
		'{"H", "T", "T", "P", "/", "1", ".", "1"}
	};
	localparam logic [3:0] VER_LEN = 4'd8;

	// scheme prefix bytes dropped from a plain target
	localparam logic [2:0] SKIP_LEN = 3'd7;

	// target sub-states, kept in the position counter
	localparam logic [3:0] TGT_START  = 4'd0;
	localparam logic [3:0] TGT_COLON0 = 4'd1;
	localparam logic [3:0] TGT_HOST   = 4'd2;
	localparam logic [3:0] TGT_COLON  = 4'd3;
	localparam logic [3:0] TGT_PORT   = 4'd4;
	localparam logic [3:0] TGT_DONE   = 4'd5;

endpackage

`default_nettype wire

>>> design/http_request_line_parser.sv
// ---------------------------------------------------------------------------
// http_request_line_parser
// Byte-wise HTTP request line parser: tags method, host, port and version
// bytes and gives one tunnel / plain / malformed verdict per message.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  req      | in  | req_valid, req_stall | hrlp_pkg::req_t (one request byte)
//  res      | out | res_valid, res_stall | hrlp_pkg::res_t (tagged byte)
//
//  One byte per cycle while req_stall is low; each result appears the cycle after its byte is taken.
//  The parse state and the result register update in that same cycle.
//  Reset clears the parse state and empties the result register.
//  req_stall follows res_stall only while a result is held; an empty or
//  draining result register lets the next byte in.
// ---------------------------------------------------------------------------
`default_nettype none

module http_request_line_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire hrlp_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_stall,
	output hrlp_pkg::res_t      res
);

	typedef enum logic [2:0] {
		PH_PRE_METHOD,
		PH_METHOD,
		PH_PRE_TARGET,
		PH_TARGET,
		PH_PRE_VERSION,
		PH_VERSION,
		PH_DONE
	} phase_t;

	phase_t         phase_q;
	logic [3:0]     pos_q;
	logic [6:0]     meth_cand_q;
	logic [1:0]     ver_cand_q;
	logic [2:0]     skip_q;
	logic           host_seen_q;
	logic           port_seen_q;
	logic           tunnel_q;
	logic           res_valid_q;
	hrlp_pkg::res_t res_q;

	phase_t         c_phase, n_phase;
	logic [3:0]     c_pos, n_pos;
	logic [6:0]     c_mc, n_mc;
	logic [1:0]     c_vc, n_vc;
	logic [2:0]     c_skip, n_skip;
	logic           c_hs, n_hs;
	logic           c_ps, n_ps;
	logic           c_tun, n_tun;

	logic           accept;
	logic           sp, ws;
	logic           meth_hit, meth_tun;
	logic           do_meth, do_ver, do_tgt, do_fin;
	logic           tslash, tcolon;
	logic [1:0]     kind;
	logic [2:0]     tag;
	hrlp_pkg::res_t res_d;

	function automatic logic ver_ok(input logic [1:0] cand, input logic [3:0] pos);
		return (cand != 2'b00) && (pos == hrlp_pkg::VER_LEN);
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = res_valid_q && res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		// a first byte restarts the parse before it is taken
		if (req.first_byte) begin
			c_phase = PH_PRE_METHOD;
			c_pos   = '0;
			c_mc    = '1;
			c_vc    = '1;
			c_skip  = '0;
			c_hs    = 1'b0;
			c_ps    = 1'b0;
			c_tun   = 1'b0;
		end else begin
			c_phase = phase_q;
			c_pos   = pos_q;
			c_mc    = meth_cand_q;
			c_vc    = ver_cand_q;
			c_skip  = skip_q;
			c_hs    = host_seen_q;
			c_ps    = port_seen_q;
			c_tun   = tunnel_q;
		end

		sp = (req.data_byte == hrlp_pkg::CH_SPACE);
		ws = sp || (req.data_byte == hrlp_pkg::CH_CR) || (req.data_byte == hrlp_pkg::CH_LF);

		meth_hit = 1'b0;
		for (int i = 0; i < hrlp_pkg::NUM_METHODS; i++) begin
			if (c_mc[i] && (hrlp_pkg::METH_LEN[i] == c_pos))
				meth_hit = 1'b1;
		end
		meth_tun = c_mc[0] && (hrlp_pkg::METH_LEN[0] == c_pos);

		n_phase = c_phase;
		n_pos   = c_pos;
		n_mc    = c_mc;
		n_vc    = c_vc;
		n_skip  = c_skip;
		n_hs    = c_hs;
		n_ps    = c_ps;
		n_tun   = c_tun;
		do_meth = 1'b0;
		do_ver  = 1'b0;
		do_tgt  = 1'b0;
		do_fin  = 1'b0;
		kind    = hrlp_pkg::VERDICT_BAD;
		tag     = hrlp_pkg::TAG_NONE;

		if (c_phase != PH_DONE && req.data_byte != hrlp_pkg::CH_NUL) begin
			unique case (c_phase)
				PH_PRE_METHOD: begin
					if (!sp) begin
						n_phase = PH_METHOD;
						n_pos   = '0;
						do_meth = 1'b1;
					end
				end
				PH_METHOD: begin
					if (!sp) begin
						do_meth = 1'b1;
					end else if (meth_hit) begin
						n_phase = PH_PRE_TARGET;
						n_tun   = meth_tun;
					end else begin
						do_fin  = 1'b1;
						n_phase = PH_DONE;
					end
				end
				PH_PRE_TARGET: begin
					if (!sp) begin
						n_phase = PH_TARGET;
						n_pos   = '0;
						n_skip  = '0;
						do_tgt  = 1'b1;
					end
				end
				PH_TARGET: begin
					if (!sp) begin
						do_tgt = 1'b1;
					end else if ((c_tun || c_skip >= hrlp_pkg::SKIP_LEN) && c_hs) begin
						n_phase = PH_PRE_VERSION;
					end else begin
						do_fin  = 1'b1;
						n_phase = PH_DONE;
					end
				end
				PH_PRE_VERSION: begin
					if (!ws) begin
						n_phase = PH_VERSION;
						n_pos   = '0;
						do_ver  = 1'b1;
					end
				end
				PH_VERSION: begin
					if (!ws) begin
						do_ver = 1'b1;
					end else begin
						do_fin  = 1'b1;
						n_phase = PH_DONE;
						if (ver_ok(c_vc, c_pos))
							kind = c_tun ? hrlp_pkg::VERDICT_TUNNEL : hrlp_pkg::VERDICT_PLAIN;
					end
				end
				default: begin
				end
			endcase
		end

		if (do_meth) begin
			for (int i = 0; i < hrlp_pkg::NUM_METHODS; i++) begin
				if (n_pos >= hrlp_pkg::METH_LEN[i] ||
						hrlp_pkg::METH_TXT[i][n_pos[2:0]] != req.data_byte)
					n_mc[i] = 1'b0;
			end
			n_pos = (n_pos == '1) ? n_pos : n_pos + 4'd1;
			tag   = hrlp_pkg::TAG_METHOD;
		end

		if (do_ver) begin
			for (int i = 0; i < 2; i++) begin
				if (n_pos >= hrlp_pkg::VER_LEN ||
						hrlp_pkg::VER_TXT[i][n_pos[2:0]] != req.data_byte)
					n_vc[i] = 1'b0;
			end
			n_pos = (n_pos == '1) ? n_pos : n_pos + 4'd1;
			tag   = hrlp_pkg::TAG_VERSION;
		end

		tslash = !n_tun && (req.data_byte == hrlp_pkg::CH_SLASH);
		tcolon = (req.data_byte == hrlp_pkg::CH_COLON);
		if (do_tgt) begin
			if (!n_tun && n_skip < hrlp_pkg::SKIP_LEN) begin
				n_skip = n_skip + 3'd1;
			end else begin
				case (n_pos) inside
					hrlp_pkg::TGT_START, hrlp_pkg::TGT_COLON0: begin
						// leading slashes are dropped before the host
						if (n_pos == hrlp_pkg::TGT_START && tslash) begin
						end else if (tcolon) begin
							n_pos = hrlp_pkg::TGT_COLON0;
						end else if (tslash) begin
							n_pos = hrlp_pkg::TGT_DONE;
						end else begin
							n_pos = hrlp_pkg::TGT_HOST;
							n_hs  = 1'b1;
							tag   = hrlp_pkg::TAG_HOST;
						end
					end
					hrlp_pkg::TGT_HOST: begin
						if (tcolon)
							n_pos = hrlp_pkg::TGT_COLON;
						else if (tslash)
							n_pos = hrlp_pkg::TGT_DONE;
						else
							tag = hrlp_pkg::TAG_HOST;
					end
					hrlp_pkg::TGT_COLON: begin
						if (tcolon) begin
						end else if (tslash) begin
							n_pos = hrlp_pkg::TGT_DONE;
						end else begin
							n_pos = hrlp_pkg::TGT_PORT;
							n_ps  = 1'b1;
							tag   = hrlp_pkg::TAG_PORT;
						end
					end
					hrlp_pkg::TGT_PORT: begin
						if (tcolon || tslash)
							n_pos = hrlp_pkg::TGT_DONE;
						else
							tag = hrlp_pkg::TAG_PORT;
					end
					default: begin
					end
				endcase
			end
		end

		// end of text: a NUL byte, or the byte flagged as last
		if (n_phase != PH_DONE &&
				(req.data_byte == hrlp_pkg::CH_NUL || req.final_byte)) begin
			do_fin = 1'b1;
			if (n_phase == PH_VERSION && ver_ok(n_vc, n_pos))
				kind = n_tun ? hrlp_pkg::VERDICT_TUNNEL : hrlp_pkg::VERDICT_PLAIN;
			n_phase = PH_DONE;
		end

		res_d.byte_out         = req.data_byte;
		res_d.field_tag        = tag;
		res_d.verdict_valid    = do_fin;
		res_d.verdict          = do_fin ? kind : hrlp_pkg::VERDICT_TUNNEL;
		res_d.use_default_port = do_fin && (kind != hrlp_pkg::VERDICT_BAD) && !n_ps;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PRE_METHOD;
			pos_q       <= '0;
			meth_cand_q <= '1;
			ver_cand_q  <= '1;
			skip_q      <= '0;
			host_seen_q <= 1'b0;
			port_seen_q <= 1'b0;
			tunnel_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (accept) begin
			phase_q     <= n_phase;
			pos_q       <= n_pos;
			meth_cand_q <= n_mc;
			ver_cand_q  <= n_vc;
			skip_q      <= n_skip;
			host_seen_q <= n_hs;
			port_seen_q <= n_ps;
			tunnel_q    <= n_tun;
			res_valid_q <= 1'b1;
			res_q       <= res_d;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> design/hrlp_checker.sv
// ---------------------------------------------------------------------------
// hrlp_checker
// Port-level checks on the request line parser, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_request_line_parser_defines.svh"

module hrlp_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire hrlp_pkg::req_t req,
	input wire logic           res_valid,
	input wire logic           res_stall,
	input wire hrlp_pkg::res_t res
);

	// a stalled result beat holds
	`HRLP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(res))

	// every accepted byte shows up in the next result beat
	`HRLP_ASSERT_NEXT(a_byte_pass, clk, arst_n, req_valid && !req_stall,
		res_valid && (res.byte_out == $past(req.data_byte)))

	// verdict fields stay quiet on beats without a verdict
	`HRLP_ASSERT_NOW(a_quiet_verdict, clk, arst_n, res_valid && !res.verdict_valid,
		(res.verdict == hrlp_pkg::VERDICT_TUNNEL) && !res.use_default_port)

	// a malformed message never selects a default port
	`HRLP_ASSERT_NOW(a_bad_no_port, clk, arst_n,
		res_valid && (res.verdict == hrlp_pkg::VERDICT_BAD), !res.use_default_port)

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire
